// ===== hdl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and functions of the aes block encryptor
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int unsigned KEY_REG_COUNT = 4;

   // configuration register indexes
   localparam logic [2:0] CSR_MODE   = 3'd0;
   localparam logic [2:0] CSR_KEY_W0 = 3'd1;
   localparam logic [2:0] CSR_KEY_W1 = 3'd2;
   localparam logic [2:0] CSR_KEY_W2 = 3'd3;
   localparam logic [2:0] CSR_KEY_W3 = 3'd4;

   // key length codes
   localparam logic [1:0] MODE_128 = 2'd0;
   localparam logic [1:0] MODE_192 = 2'd1;

   typedef logic [127:0] block_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] r;
      case (x)
         8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
         8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
         8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
         8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
         8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
         8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
         8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
         8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
         8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
         8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
         8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
         8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
         8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
         8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
         8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
         8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
         8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
         8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
         8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
         8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
         8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
         8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
         8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
         8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
         8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
         8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
         8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
         8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
         8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
         8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
         8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
         8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
         8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
         8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
         8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
         8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
         8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
         8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
         8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
         8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
         8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
         8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
         8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
         8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
         8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
         8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
         8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
         8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
         8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
         8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
         8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
         8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
         8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
         8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
         8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
         8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
         8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
         8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
         8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
         8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
         8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
         8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
         8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
         8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] x);
      return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // round constant for schedule group q (1 to 10)
   function automatic logic [31:0] rcon(input logic [3:0] q);
      logic [7:0] r;
      case (q)
         4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
         4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
         4'd9: r = 8'h1b; 4'd10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return {r, 24'h000000};
   endfunction

   // subbytes and shiftrows on a big-endian block (byte 0 in the top bits)
   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic block_type mix_columns(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

endpackage

// ===== hdl/aes_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// aes_block_encrypt
// aes-128/192/256 ecb block encryptor with a memory-held key schedule
// ----------------------------------------------------------------------------
// usage:
//   csr_ port writes the key length code (index 0) and the four 64-bit key
//   words (indexes 1 to 4) while the block is idle.
//   req_ carries one plaintext block per transaction; rsp_ returns one
//   ciphertext block per transaction, in order.
// operation:
//   each block first expands the key schedule into the round-key memory,
//   one 32-bit word per cycle (44, 52 or 60 words), then does a priming
//   read and runs a single round unit (initial key add and 10, 12 or 14
//   rounds), reading four round-key words from the memory as one 128-bit
//   row per round. the schedule is expanded anew for every block, and a
//   new block is accepted only once the previous result has been taken.
// reset:
//   reset clears the key registers, key length and control; the round-key
//   memory is not cleared, it is always written before being used.
// stall:
//   the result waits in the output register until rsp_ready; the next
//   plaintext transaction is accepted only once the result has been taken.
// ----------------------------------------------------------------------------
module aes_block_encrypt
   import aes_pkg::*;
#(
   parameter int unsigned ROUND_KEY_WORDS = 60
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_plain_upper,
   input  logic [63:0] req_plain_lower,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_cipher_upper,
   output logic [63:0] rsp_cipher_lower,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int unsigned ROWS   = (ROUND_KEY_WORDS + 3) / 4;
   localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXP  = 3'd1;
   localparam logic [2:0] ST_PRIM = 3'd2;
   localparam logic [2:0] ST_RND  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   // round-key memory, one row holds four words of one round
   logic [127:0] rk_mem [ROWS];
   logic [127:0] rk_rd_ff;

   logic [1:0]  mode_ff;
   logic [63:0] key_ff [KEY_REG_COUNT];
   logic [2:0]  state_ff, state_in;
   logic [5:0]  widx_ff, widx_in;
   logic [3:0]  round_ff, round_in;
   logic [255:0] win_ff, win_in;     // last eight schedule words, newest low
   logic [127:0] row_ff, row_in;     // row being assembled
   block_type   blk_ff, blk_in;
   logic [127:0] out_ff, out_in;
   logic        wr_en;
   logic [5:0]  wr_word;
   logic [3:0]  nk, nr;
   logic [5:0]  total;
   logic [31:0] new_word, t_word, prev_nk, prev_1;
   logic [2:0]  imod;
   logic [3:0]  iq;
   logic [5:0]  rd_row;
   logic [127:0] rk_eff;
   block_type   ss, mc, nxt;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_128;
         for (int k = 0; k < KEY_REG_COUNT; k++) key_ff[k] <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= csr_data[1:0];
            CSR_KEY_W0: key_ff[0] <= csr_data;
            CSR_KEY_W1: key_ff[1] <= csr_data;
            CSR_KEY_W2: key_ff[2] <= csr_data;
            CSR_KEY_W3: key_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // key length decode
   always_comb begin
      case (mode_ff)
         MODE_128: begin nk = 4'd4; nr = 4'd10; end
         MODE_192: begin nk = 4'd6; nr = 4'd12; end
         default:  begin nk = 4'd8; nr = 4'd14; end
      endcase
      total = 6'({nr, 2'b00}) + 6'd4;
   end

   // schedule word generator: i mod nk and i / nk tracked by counters
   logic [2:0] cmod_ff, cmod_in;
   logic [3:0] cq_ff, cq_in;
   always_comb begin
      imod = cmod_ff;
      iq   = cq_ff;
      prev_1  = win_ff[31:0];
      prev_nk = win_ff[32 * nk - 1 -: 32];
      t_word  = prev_1;
      if (imod == 3'd0) begin
         t_word = sub_word({prev_1[23:0], prev_1[31:24]}) ^ rcon(iq);
      end else if (nk == 4'd8 && imod == 3'd4) begin
         t_word = sub_word(prev_1);
      end
      if (widx_ff < 6'(nk)) begin
         new_word = key_ff[widx_ff[2:1]][widx_ff[0] ? 31 : 63 -: 32];
      end else begin
         new_word = prev_nk ^ t_word;
      end
   end

   // round datapath, words at or beyond the store size read as zero
   always_comb begin
      rk_eff = '0;
      for (int c = 0; c < 4; c++) begin
         if ({26'd0, round_ff, 2'(c)} < 32'(ROUND_KEY_WORDS)) begin
            rk_eff[127 - 32 * c -: 32] = rk_rd_ff[127 - 32 * c -: 32];
         end
      end
      ss  = sub_shift(blk_ff);
      mc  = mix_columns(ss);
      nxt = (round_ff == nr) ? ss : mc;
   end

   // control
   always_comb begin
      state_in = state_ff;
      widx_in  = widx_ff;
      round_in = round_ff;
      win_in   = win_ff;
      row_in   = row_ff;
      blk_in   = blk_ff;
      out_in   = out_ff;
      cmod_in  = cmod_ff;
      cq_in    = cq_ff;
      wr_en    = 1'b0;
      wr_word  = widx_ff;
      rd_row   = 6'(round_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               blk_in   = {req_plain_upper, req_plain_lower};
               widx_in  = '0;
               cmod_in  = '0;
               cq_in    = '0;
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            win_in = {win_ff[223:0], new_word};
            row_in = {row_ff[95:0], new_word};
            wr_en  = (widx_ff[1:0] == 2'd3);
            widx_in = widx_ff + 6'd1;
            if ({1'b0, cmod_ff} == nk - 4'd1) begin
               cmod_in = '0;
               cq_in   = cq_ff + 4'd1;
            end else begin
               cmod_in = cmod_ff + 3'd1;
            end
            if (widx_ff == total - 6'd1) begin
               round_in = '0;
               state_in = ST_PRIM;
            end
         end
         ST_PRIM: begin
            // read row 0, next cycle it is applied
            rd_row   = '0;
            round_in = '0;
            state_in = ST_RND;
         end
         ST_RND: begin
            rd_row = 6'(round_ff) + 6'd1;
            if (round_ff == 4'd0) begin
               blk_in = blk_ff ^ rk_eff;
            end else begin
               blk_in = nxt ^ rk_eff;
            end
            round_in = round_ff + 4'd1;
            if (round_ff == nr) begin
               out_in   = nxt ^ rk_eff;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // round-key memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en && ({26'd0, wr_word[5:2]} < 30'(ROWS))) begin
         rk_mem[wr_word[ROW_W + 1:2]] <= row_in;
      end
      rk_rd_ff <= rk_mem[rd_row[ROW_W - 1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         widx_ff  <= '0;
         round_ff <= '0;
         cmod_ff  <= '0;
         cq_ff    <= '0;
      end else begin
         state_ff <= state_in;
         widx_ff  <= widx_in;
         round_ff <= round_in;
         cmod_ff  <= cmod_in;
         cq_ff    <= cq_in;
      end
      win_ff <= win_in;
      row_ff <= row_in;
      blk_ff <= blk_in;
      out_ff <= out_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_cipher_upper = out_ff[127:64];
   assign rsp_cipher_lower = out_ff[63:0];

endmodule

// ===== tb/aes_block_encrypt_tb.sv =====
// ----------------------------------------------------------------------------
// aes_block_encrypt_tb
// self-checking bench: plaintext blocks go in under several key settings, an
// in-bench aes model predicts every ciphertext, and the monitor compares them
// ----------------------------------------------------------------------------
module aes_block_encrypt_tb;
   import aes_pkg::*;

   localparam logic [1:0] MODE_256    = 2'd2;
   localparam logic [1:0] MODE_SPARE  = 2'd3;
   localparam logic [2:0] CSR_UNUSED5 = 3'd5;
   localparam logic [2:0] CSR_UNUSED7 = 3'd7;
   localparam int         SCHED_WORDS = 60;
   localparam int         RANDOM_ITEMS = 1400;

   typedef struct packed {
      logic [63:0] upper;
      logic [63:0] lower;
   } block_pair_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_plain_upper;
   logic [63:0] req_plain_lower;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_cipher_upper;
   logic [63:0] rsp_cipher_lower;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   // shadow configuration for the predictor
   logic [1:0]  key_mode;
   logic [63:0] key_word_regs [4];

   block_pair_t plain_queue[$];
   block_pair_t cipher_expected[$];
   int          error_count;
   int          mismatch_count;
   bit          hold_off_request;
   bit          idle_inputs;
   bit          in_taken;

   aes_block_encrypt DUT (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      #40000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // byte-level aes helpers
   function automatic logic [7:0] gf_double(input logic [7:0] b);
      return (b << 1) ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] sub_byte(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,
            8'hfe,8'hd7,8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
            8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,
            8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,
            8'heb,8'h27,8'hb2,8'h75,8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
            8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,
            8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,
            8'h50,8'h3c,8'h9f,8'ha8,8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
            8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,8'hcd,8'h0c,8'h13,8'hec,
            8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,
            8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
            8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,
            8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,
            8'h4b,8'hbd,8'h8b,8'h8a,8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
            8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,8'he1,8'hf8,8'h98,8'h11,
            8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,
            8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [31:0] sub_all(input logic [31:0] w);
      return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
   endfunction

   // full encryption of one block under the shadowed key setting
   function automatic block_pair_t encrypt_block(input block_pair_t plain);
      logic [31:0] sched [SCHED_WORDS];
      logic [31:0] tmp;
      logic [7:0]  st [16];
      logic [7:0]  nx [16];
      logic [7:0]  a0, a1, a2, a3, al;
      logic [7:0]  rc;
      logic [63:0] kr;
      int          nk, nr, total;
      block_pair_t res;
      case (key_mode)
         MODE_128: begin nk = 4; nr = 10; end
         MODE_192: begin nk = 6; nr = 12; end
         default:  begin nk = 8; nr = 14; end
      endcase
      total = 4 * (nr + 1);
      rc = 8'h01;
      for (int i = 0; i < total; i++) begin
         if (i < nk) begin
            kr = key_word_regs[i / 2];
            sched[i] = (i % 2) ? kr[31:0] : kr[63:32];
         end else begin
            tmp = sched[i - 1];
            if (i % nk == 0) begin
               tmp = sub_all({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
               rc = gf_double(rc);
            end else if (nk == 8 && i % nk == 4) begin
               tmp = sub_all(tmp);
            end
            sched[i] = sched[i - nk] ^ tmp;
         end
      end
      for (int i = 0; i < 8; i++) begin
         st[i]     = plain.upper[63 - 8 * i -: 8];
         st[8 + i] = plain.lower[63 - 8 * i -: 8];
      end
      for (int rnd = 0; rnd <= nr; rnd++) begin
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  nx[4 * c + r] = sub_byte(st[4 * ((c + r) % 4) + r]);
            st = nx;
            if (rnd < nr) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                  al = a0 ^ a1 ^ a2 ^ a3;
                  st[4*c]   = a0 ^ al ^ gf_double(a0 ^ a1);
                  st[4*c+1] = a1 ^ al ^ gf_double(a1 ^ a2);
                  st[4*c+2] = a2 ^ al ^ gf_double(a2 ^ a3);
                  st[4*c+3] = a3 ^ al ^ gf_double(a3 ^ a0);
               end
            end
         end
         for (int c = 0; c < 4; c++) begin
            tmp = sched[4 * rnd + c];
            st[4*c]   ^= tmp[31:24];
            st[4*c+1] ^= tmp[23:16];
            st[4*c+2] ^= tmp[15:8];
            st[4*c+3] ^= tmp[7:0];
         end
      end
      for (int i = 0; i < 8; i++) begin
         res.upper[63 - 8 * i -: 8] = st[i];
         res.lower[63 - 8 * i -: 8] = st[8 + i];
      end
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // gap length: mostly short, sometimes long
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver
   int send_gap;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (req_valid && !in_taken) begin
         // hold the offered transaction
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (plain_queue.size() > 0 && !idle_inputs) begin
         req_valid       <= 1'b1;
         req_plain_upper <= plain_queue[0].upper;
         req_plain_lower <= plain_queue[0].lower;
         void'(plain_queue.pop_front());
         send_gap        <= (idle_inputs) ? 0 : gap_len();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // predictor: every accepted transaction yields one expected ciphertext
   always @(posedge clock) begin
      block_pair_t plain;
      in_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         plain.upper = req_plain_upper;
         plain.lower = req_plain_lower;
         cipher_expected.push_back(encrypt_block(plain));
      end
   end

   // receiver backpressure
   int stall_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (hold_off_request) begin
         rsp_ready  <= 1'b0;
         stall_left <= 300;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= gap_len();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      block_pair_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cipher_expected.size() == 0) begin
            error_count++;
            if (mismatch_count++ < 10)
               $display("unexpected transaction %h %h", rsp_cipher_upper, rsp_cipher_lower);
         end else begin
            want = cipher_expected.pop_front();
            if (want.upper !== rsp_cipher_upper || want.lower !== rsp_cipher_lower) begin
               error_count++;
               if (mismatch_count++ < 10)
                  $display("cipher mismatch: expected %h %h got %h %h",
                           want.upper, want.lower, rsp_cipher_upper, rsp_cipher_lower);
            end
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_MODE) key_mode = value[1:0];
      else if (idx <= CSR_KEY_W3) key_word_regs[idx - 1] = value;
   endtask

   task automatic load_key(input logic [1:0] mode, input logic [63:0] k0, k1, k2, k3);
      write_reg(CSR_MODE, {62'd0, mode});
      write_reg(CSR_KEY_W0, k0);
      write_reg(CSR_KEY_W1, k1);
      write_reg(CSR_KEY_W2, k2);
      write_reg(CSR_KEY_W3, k3);
   endtask

   task automatic queue_block(input logic [63:0] up, input logic [63:0] lo);
      block_pair_t b;
      b.upper = up;
      b.lower = lo;
      plain_queue.push_back(b);
   endtask

   // wait until every queued transaction is sent and every result returned
   task automatic drain();
      while (plain_queue.size() > 0 || req_valid || cipher_expected.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // random payload: plain random, or sparse/dense patterns
   task automatic queue_random(input int n);
      int kind;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) queue_block(64'd0, rand64() & {$urandom, $urandom});
         else if (kind == 1) queue_block(~(rand64() & rand64()), 64'hffff_ffff_ffff_ffff);
         else queue_block(rand64(), rand64());
      end
   endtask

   initial begin
      error_count      = 0;
      mismatch_count   = 0;
      hold_off_request = 1'b0;
      idle_inputs      = 1'b0;
      key_mode         = MODE_128;
      for (int i = 0; i < 4; i++) key_word_regs[i] = 64'd0;
      req_valid        = 1'b0;
      req_plain_upper  = 64'd0;
      req_plain_lower  = 64'd0;
      rsp_ready        = 1'b0;
      csr_write        = 1'b0;
      csr_index        = CSR_MODE;
      csr_data         = 64'd0;
      reset            = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset key, then published vectors for each key length
      queue_block(64'd0, 64'd0);
      queue_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      drain();
      load_key(MODE_128, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
               64'hdead_beef_dead_beef, 64'hffff_ffff_ffff_ffff);
      queue_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      queue_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
      drain();
      write_reg(CSR_MODE, {62'd0, MODE_192});
      write_reg(CSR_KEY_W2, 64'h1011_1213_1415_1617);
      queue_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      drain();
      write_reg(CSR_MODE, {62'd0, MODE_256});
      write_reg(CSR_KEY_W3, 64'h18191a1b_1c1d1e1f);
      queue_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      queue_block(64'hffff_ffff_ffff_ffff, 64'd0);
      drain();
      // spare mode code behaves as the 256-bit key; writes off the map are dropped
      write_reg(CSR_MODE, {62'h3fff_ffff_ffff_ffff, MODE_SPARE});
      write_reg(CSR_UNUSED5, 64'hffff_ffff_ffff_ffff);
      write_reg(CSR_UNUSED7, 64'h1234_5678_9abc_def0);
      queue_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      queue_block(64'd0, 64'hffff_ffff_ffff_ffff);
      drain();
      load_key(MODE_128, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
               64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      queue_block(64'd0, 64'd0);
      queue_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      drain();

      // long receiver hold-off while the sender keeps offering
      queue_random(12);
      repeat (5) @(negedge clock);
      hold_off_request = 1'b1;
      repeat (2) @(posedge clock);
      hold_off_request = 1'b0;
      drain();

      // random phases across key settings, extremes included
      for (int ph = 0; ph < 14; ph++) begin
         case (ph % 4)
            0: load_key(MODE_128, rand64(), rand64(), rand64(), rand64());
            1: load_key(MODE_192, rand64(), rand64(), rand64(), rand64());
            2: load_key(MODE_256, rand64(), rand64(), rand64(), rand64());
            default: load_key(MODE_SPARE, rand64(), rand64(), rand64(), rand64());
         endcase
         if (ph == 13) load_key(MODE_256, 64'd0, 64'd0, 64'd0, 64'd0);
         idle_inputs = 1'b0;
         queue_random(RANDOM_ITEMS / 14);
         drain();
      end

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/aes_pkg.sv
hdl/aes_block_encrypt.sv
tb/aes_block_encrypt_tb.sv
